// ----- rtl/core/skct_pkg.sv -----
// shared types, constants and codes for the sorted keyed count table
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package skct_pkg;

    // table geometry
    localparam int DEPTH   = 32;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W  = ADDR_W + 1;

    // field widths
    localparam int TYPE_W  = 3;
    localparam int KEY_W   = 31;
    localparam int QTY_W   = 32;
    localparam int STAT_W  = 3;
    localparam int TOTAL_W = 6;

    localparam logic [FILL_W-1:0] FILL_ONE  = {{(FILL_W-1){1'b0}}, 1'b1};
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);
    localparam logic [QTY_W-1:0]  QTY_MAX   = {1'b0, {(QTY_W-1){1'b1}}};
    localparam logic [QTY_W-1:0]  QTY_MIN   = {1'b1, {(QTY_W-1){1'b0}}};

    // request codes
    localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_SEARCH = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_UPDATE = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_ERASE  = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_LIST   = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;

    // index counter operations
    localparam logic [2:0] IDX_HOLD     = 3'd0;
    localparam logic [2:0] IDX_CLEAR    = 3'd1;
    localparam logic [2:0] IDX_INC      = 3'd2;
    localparam logic [2:0] IDX_DEC      = 3'd3;
    localparam logic [2:0] IDX_FILL     = 3'd4;
    localparam logic [2:0] IDX_HIT_NEXT = 3'd5;

    // read address select
    localparam logic RA_IDX     = 1'b0;
    localparam logic RA_IDX_DEC = 1'b1;

    // result key select
    localparam logic [1:0] KS_REQ   = 2'd0;
    localparam logic [1:0] KS_ENTRY = 2'd1;
    localparam logic [1:0] KS_ZERO  = 2'd2;

    // result quantity select
    localparam logic [2:0] QS_ZERO  = 3'd0;
    localparam logic [2:0] QS_HIT   = 3'd1;
    localparam logic [2:0] QS_AMT   = 3'd2;
    localparam logic [2:0] QS_SUM   = 3'd3;
    localparam logic [2:0] QS_ENTRY = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [QTY_W-1:0] qty;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic [2:0]        idx_op;
        logic              rd_en;
        logic              rd_sel;
        logic              scan_en;
        logic              shift_up;
        logic              shift_down;
        logic              wr_new;
        logic              wr_update;
        logic              fill_inc;
        logic              fill_dec;
        logic              emit;
        logic [STAT_W-1:0] emit_status;
        logic [1:0]        emit_key_sel;
        logic [2:0]        emit_qty_sel;
        logic              emit_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic              hit;
        logic              full;
        logic              fill_zero;
        logic              idx_eq_fill;
        logic              idx_eq_pos;
        logic              rd_vld;
        logic              rd_last;
    } t_dp_stat;

endpackage

// ----- rtl/core/skct_datapath.sv -----
// datapath: entry memory, request registers, scan compare, shift and result registers
// depends on skct_pkg
`timescale 1ns / 1ps

module skct_datapath import skct_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [TYPE_W-1:0]       i_req_type,
    input  logic [KEY_W-1:0]        i_part_key,
    input  logic signed [QTY_W-1:0] i_amount,
    output t_dp_stat                o_stat,
    output logic                    o_valid,
    output logic [STAT_W-1:0]       o_status,
    output logic [KEY_W-1:0]        o_out_key,
    output logic signed [QTY_W-1:0] o_out_quantity,
    output logic [TOTAL_W-1:0]      o_entry_total,
    output logic                    o_last
);

    // entry memory, one write and one registered read per cycle
    t_entry r_mem [DEPTH];

    logic [TYPE_W-1:0]  r_type;
    logic [KEY_W-1:0]   r_key;
    logic [QTY_W-1:0]   r_amt;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic [FILL_W-1:0]  r_idx;
    logic [FILL_W-1:0]  n_idx;
    logic [FILL_W-1:0]  r_pos;
    logic               r_hit;
    logic [ADDR_W-1:0]  r_hit_idx;
    logic [QTY_W-1:0]   r_hit_qty;
    logic               r_rd_vld;
    logic [ADDR_W-1:0]  r_rd_idx;
    t_entry             r_rd_data;

    logic               r_o_valid;
    logic [STAT_W-1:0]  r_o_status;
    logic [KEY_W-1:0]   r_o_key;
    logic [QTY_W-1:0]   r_o_qty;
    logic [TOTAL_W-1:0] r_o_total;
    logic               r_o_last;

    logic [FILL_W-1:0]  idx_dec;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    t_entry             wr_data;
    logic [QTY_W:0]     sum;
    logic [QTY_W-1:0]   sat_sum;
    logic [KEY_W-1:0]   emit_key;
    logic [QTY_W-1:0]   emit_qty;

    assign idx_dec = r_idx - FILL_ONE;
    assign rd_addr = (i_cmd.rd_sel == RA_IDX_DEC) ? idx_dec[ADDR_W-1:0] : r_idx[ADDR_W-1:0];

    // saturating add for update
    assign sum = {r_hit_qty[QTY_W-1], r_hit_qty} + {r_amt[QTY_W-1], r_amt};
    always_comb begin
        if (sum[QTY_W] != sum[QTY_W-1]) begin
            sat_sum = sum[QTY_W] ? QTY_MIN : QTY_MAX;
        end else begin
            sat_sum = sum[QTY_W-1:0];
        end
    end

    // entry count
    always_comb begin
        n_fill = r_fill;
        if (i_cmd.fill_inc) begin
            n_fill = r_fill + FILL_ONE;
        end else if (i_cmd.fill_dec) begin
            n_fill = r_fill - FILL_ONE;
        end
    end

    // index counter
    always_comb begin
        unique case (i_cmd.idx_op)
            IDX_CLEAR:    n_idx = '0;
            IDX_INC:      n_idx = r_idx + FILL_ONE;
            IDX_DEC:      n_idx = idx_dec;
            IDX_FILL:     n_idx = r_fill;
            IDX_HIT_NEXT: n_idx = {1'b0, r_hit_idx} + FILL_ONE;
            default:      n_idx = r_idx;
        endcase
    end

    // write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rd_idx;
        wr_data = r_rd_data;
        if (i_cmd.wr_new) begin
            wr_en   = 1'b1;
            wr_addr = r_pos[ADDR_W-1:0];
            wr_data = '{key: r_key, qty: r_amt};
        end else if (i_cmd.wr_update) begin
            wr_en   = 1'b1;
            wr_addr = r_hit_idx;
            wr_data = '{key: r_key, qty: sat_sum};
        end else if (i_cmd.shift_up && r_rd_vld) begin
            wr_en   = 1'b1;
            wr_addr = r_rd_idx + 1'b1;
        end else if (i_cmd.shift_down && r_rd_vld) begin
            wr_en   = 1'b1;
            wr_addr = r_rd_idx - 1'b1;
        end
    end

    // memory access
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_idx  <= rd_addr;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_idx     <= n_idx;
            r_rd_vld  <= i_cmd.rd_en;
            r_o_valid <= i_cmd.emit;
        end
    end

    // request capture and scan compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_req_type;
            r_key  <= i_part_key;
            r_amt  <= i_amount;
            r_hit  <= 1'b0;
            r_pos  <= '0;
        end else if (i_cmd.scan_en && r_rd_vld) begin
            if (r_rd_data.key == r_key) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
                r_hit_qty <= r_rd_data.qty;
            end
            if (r_rd_data.key < r_key) begin
                r_pos <= r_pos + FILL_ONE;
            end
        end
    end

    // result field select
    always_comb begin
        case (i_cmd.emit_key_sel)
            KS_ENTRY: emit_key = r_rd_data.key;
            KS_ZERO:  emit_key = '0;
            default:  emit_key = r_key;
        endcase
        case (i_cmd.emit_qty_sel)
            QS_HIT:   emit_qty = r_hit_qty;
            QS_AMT:   emit_qty = r_amt;
            QS_SUM:   emit_qty = sat_sum;
            QS_ENTRY: emit_qty = r_rd_data.qty;
            default:  emit_qty = '0;
        endcase
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status <= i_cmd.emit_status;
            r_o_key    <= emit_key;
            r_o_qty    <= emit_qty;
            r_o_total  <= TOTAL_W'(n_fill);
            r_o_last   <= i_cmd.emit_last;
        end
    end

    // status to controller
    assign o_stat.req_type    = r_type;
    assign o_stat.hit         = r_hit;
    assign o_stat.full        = (r_fill == FILL_FULL);
    assign o_stat.fill_zero   = (r_fill == '0);
    assign o_stat.idx_eq_fill = (r_idx == r_fill);
    assign o_stat.idx_eq_pos  = (r_idx == r_pos);
    assign o_stat.rd_vld      = r_rd_vld;
    assign o_stat.rd_last     = ({1'b0, r_rd_idx} == (r_fill - FILL_ONE));

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_out_key      = r_o_key;
    assign o_out_quantity = r_o_qty;
    assign o_entry_total  = r_o_total;
    assign o_last         = r_o_last;

endmodule

// ----- rtl/core/skct_controller.sv -----
// controller: request sequencing for scan, shift, update and list
// depends on skct_pkg; drives skct_datapath through t_dp_cmd
`timescale 1ns / 1ps

module skct_controller import skct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TYPE_W-1:0] i_req_type,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd,
    output logic              o_busy
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCAN      = 3'd1;
    localparam logic [2:0] S_DECIDE    = 3'd2;
    localparam logic [2:0] S_INS_SHIFT = 3'd3;
    localparam logic [2:0] S_INS_WRITE = 3'd4;
    localparam logic [2:0] S_ERA_SHIFT = 3'd5;
    localparam logic [2:0] S_ERA_DONE  = 3'd6;
    localparam logic [2:0] S_LIST      = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state            = r_state;
        o_cmd              = '0;
        o_cmd.idx_op       = IDX_HOLD;
        o_cmd.rd_sel       = RA_IDX;
        o_cmd.emit_status  = ST_OK;
        o_cmd.emit_key_sel = KS_REQ;
        o_cmd.emit_qty_sel = QS_ZERO;
        o_cmd.emit_last    = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.idx_op = IDX_CLEAR;
                    unique case (i_req_type) inside
                        REQ_INSERT, REQ_SEARCH, REQ_UPDATE, REQ_ERASE: n_state = S_SCAN;
                        REQ_LIST: n_state = S_LIST;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end

            // read every held entry; compare runs in the cycle after the read
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (!i_stat.idx_eq_fill) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.idx_op = IDX_INC;
                end else begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_state = S_IDLE;
                unique case (i_stat.req_type)
                    REQ_SEARCH: begin
                        o_cmd.emit         = 1'b1;
                        o_cmd.emit_status  = i_stat.hit ? ST_OK : ST_NOT_FOUND;
                        o_cmd.emit_qty_sel = i_stat.hit ? QS_HIT : QS_ZERO;
                    end
                    REQ_UPDATE: begin
                        o_cmd.emit         = 1'b1;
                        o_cmd.wr_update    = i_stat.hit;
                        o_cmd.emit_status  = i_stat.hit ? ST_OK : ST_NOT_FOUND;
                        o_cmd.emit_qty_sel = i_stat.hit ? QS_SUM : QS_ZERO;
                    end
                    REQ_INSERT: begin
                        if (i_stat.hit) begin
                            o_cmd.emit         = 1'b1;
                            o_cmd.emit_status  = ST_EXISTS;
                            o_cmd.emit_qty_sel = QS_HIT;
                        end else if (i_stat.full) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_FULL;
                        end else begin
                            o_cmd.idx_op = IDX_FILL;
                            n_state      = S_INS_SHIFT;
                        end
                    end
                    REQ_ERASE: begin
                        if (i_stat.hit) begin
                            o_cmd.idx_op = IDX_HIT_NEXT;
                            n_state      = S_ERA_SHIFT;
                        end else begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = ST_NOT_FOUND;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end

            // move entries above the insert point up by one, top first
            S_INS_SHIFT: begin
                o_cmd.shift_up = 1'b1;
                if (!i_stat.idx_eq_pos) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_IDX_DEC;
                    o_cmd.idx_op = IDX_DEC;
                end else begin
                    n_state = S_INS_WRITE;
                end
            end

            S_INS_WRITE: begin
                o_cmd.wr_new       = 1'b1;
                o_cmd.fill_inc     = 1'b1;
                o_cmd.emit         = 1'b1;
                o_cmd.emit_qty_sel = QS_AMT;
                n_state            = S_IDLE;
            end

            // close the gap left by the erased entry, bottom first
            S_ERA_SHIFT: begin
                o_cmd.shift_down = 1'b1;
                if (!i_stat.idx_eq_fill) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.idx_op = IDX_INC;
                end else begin
                    n_state = S_ERA_DONE;
                end
            end

            S_ERA_DONE: begin
                o_cmd.fill_dec = 1'b1;
                o_cmd.emit     = 1'b1;
                n_state        = S_IDLE;
            end

            // stream entries in order, one per cycle
            S_LIST: begin
                if (i_stat.fill_zero) begin
                    o_cmd.emit         = 1'b1;
                    o_cmd.emit_status  = ST_EMPTY;
                    o_cmd.emit_key_sel = KS_ZERO;
                    n_state            = S_IDLE;
                end else begin
                    if (!i_stat.idx_eq_fill) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.idx_op = IDX_INC;
                    end
                    if (i_stat.rd_vld) begin
                        o_cmd.emit         = 1'b1;
                        o_cmd.emit_key_sel = KS_ENTRY;
                        o_cmd.emit_qty_sel = QS_ENTRY;
                        o_cmd.emit_last    = i_stat.rd_last;
                        if (i_stat.rd_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/sorted_keyed_count_table.sv -----
// top level of the sorted keyed count table
// depends on skct_pkg, skct_controller and skct_datapath
//
//   channel   direction  handshake             payload
//   request   in         start high, busy low  i_req_type, i_part_key, i_amount
//   result    out        o_valid for one cycle o_status, o_out_key, o_out_quantity,
//                                              o_entry_total, o_last
//
// all requests but list scan every held entry; search, update and a failed insert or
// erase then register a result. insert moves the entries above the insert point up and
// writes the new entry; erase moves those above the erased entry down. list returns
// entries in order, one per cycle, or ST_EMPTY if empty; the memory has one read port.
// synchronous active-low reset empties the table at once; no clearing pass.
// results cannot be stalled; busy stays high until the last result is driven.
`timescale 1ns / 1ps

module sorted_keyed_count_table import skct_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [TYPE_W-1:0]       i_req_type,
    input  logic [KEY_W-1:0]        i_part_key,
    input  logic signed [QTY_W-1:0] i_amount,
    output logic                    o_valid,
    output logic [STAT_W-1:0]       o_status,
    output logic [KEY_W-1:0]        o_out_key,
    output logic signed [QTY_W-1:0] o_out_quantity,
    output logic [TOTAL_W-1:0]      o_entry_total,
    output logic                    o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing
    skct_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_busy     (busy)
    );

    // storage and result generation
    skct_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_req_type     (i_req_type),
        .i_part_key     (i_part_key),
        .i_amount       (i_amount),
        .o_stat         (dp_stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_key      (o_out_key),
        .o_out_quantity (o_out_quantity),
        .o_entry_total  (o_entry_total),
        .o_last         (o_last)
    );

endmodule
